### hw/rtl/aslc_pkg.sv
// ----------------------------------------------------------------------------
// Alarm status LED controller package
// Shared widths, register indexes, alarm codes and color constants.
// ----------------------------------------------------------------------------
`default_nettype none

package aslc_pkg;

    localparam int GAS_W  = 12;
    localparam int TEMP_W = 14;
    localparam int PER_W  = 16;
    localparam int TOG_W  = 4;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 3;

    typedef logic [GAS_W-1:0]         t_gas;
    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [PER_W-1:0]         t_period;
    typedef logic [TOG_W-1:0]         t_toggles;
    typedef logic [2:0]               t_kind;
    typedef logic [1:0]               t_sev;
    typedef logic [7:0]               t_chan;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_GAS_ALERT    = 3'd0;
    localparam logic [CIDX_W-1:0] REG_GAS_WARNING  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_TEMP_HIGH    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_TEMP_LOW     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_BLINK_PERIOD = 3'd4;
    localparam logic [CIDX_W-1:0] REG_FLASH_PERIOD = 3'd5;
    localparam logic [CIDX_W-1:0] REG_BLINK_COUNT  = 3'd6;

    // Register reset values.
    localparam t_gas     GAS_ALERT_RST    = 12'd1000;
    localparam t_gas     GAS_WARNING_RST  = 12'd500;
    localparam t_temp    TEMP_HIGH_RST    = 14'sd960;
    localparam t_temp    TEMP_LOW_RST     = -14'sd320;
    localparam t_period  BLINK_PERIOD_RST = 16'd300;
    localparam t_period  FLASH_PERIOD_RST = 16'd500;
    localparam t_toggles BLINK_COUNT_RST  = 4'd6;

    // Alarm kinds and severities.
    localparam t_kind KIND_NONE    = 3'd0;
    localparam t_kind KIND_GAS     = 3'd1;
    localparam t_kind KIND_WARNING = 3'd2;
    localparam t_kind KIND_HOT     = 3'd3;
    localparam t_kind KIND_COLD    = 3'd4;

    localparam t_sev SEV_LOW    = 2'd0;
    localparam t_sev SEV_MEDIUM = 2'd1;
    localparam t_sev SEV_HIGH   = 2'd2;

    // Color levels.
    localparam t_chan CH_OFF   = 8'd0;
    localparam t_chan CH_FULL  = 8'd255;
    localparam t_chan CH_AMBER = 8'd165;
    localparam t_chan CH_DIM   = 8'd150;

    // Gradient: floor(gas*255/3000) = floor(((gas*17) >> 3) / 25), and the
    // division by 25 is a multiplication by ceil(2^19/25) and a shift by 19.
    localparam int          GRAD_Z_W    = 14;
    localparam int          GRAD_SHIFT  = 19;
    localparam logic [14:0] GRAD_RECIP  = 15'd20972;
    localparam int          GRAD_PROD_W = 29;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_colour;

    // LED control from the link sequencer to the color select.
    typedef struct packed {
        logic refresh;
        logic show_alarm;
        logic blue_full;
        logic blue_dim;
    } t_led_ctl;

endpackage

`default_nettype wire

### hw/rtl/alarm_status_led_controller.sv
// ----------------------------------------------------------------------------
// Alarm status LED controller
// Classifies each sensor sample into an alarm and produces the LED color,
// including the link-loss blink and the offline flash.
//
// Usage: samples enter on the input channel (i_valid, o_stall) and one
// result item leaves on the output channel (o_valid, i_stall) for every
// sample, in order. An item passes through an input register and a result
// register, from which its result is offered. One item is accepted every
// cycle while the output side takes results; the classifier and the link
// sequencer both work on the item that is held in the input register.
// When the receiver stalls, the held result stays in place, the item in the
// input register waits, and o_stall rises once both are full. Reset clears
// both registers, the link sequencer state (link taken as down, no blink
// pending, phases dark, timestamps zero) and sets the configuration
// registers to their default values. Configuration is written through
// i_cfg_we, i_cfg_idx and i_cfg_wdata while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_status_led_controller
    import aslc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire t_gas               i_gas_level,
    input  wire t_temp              i_object_temp,
    input  wire logic               i_temp_valid,
    input  wire logic               i_link_up,
    input  wire logic [31:0]        i_now_ms,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output t_kind                   o_alarm_kind,
    output t_sev                    o_alarm_severity,
    output logic                    o_led_refresh,
    output t_chan                   o_led_red,
    output t_chan                   o_led_green,
    output t_chan                   o_led_blue,
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata
);

    t_gas     r_gas_alert;
    t_gas     r_gas_warning;
    t_temp    r_temp_high;
    t_temp    r_temp_low;
    t_period  r_blink_period;
    t_period  r_flash_period;
    t_toggles r_blink_count;

    logic                 r_in_valid;
    t_gas                 r_in_gas;
    t_temp                r_in_temp;
    logic                 r_in_tvalid;
    logic                 r_in_link;
    logic [TIME_BITS-1:0] r_in_now;

    logic    r_out_valid;
    t_kind   r_out_kind;
    t_sev    r_out_sev;
    logic    r_out_refresh;
    t_colour r_out_colour;

    logic     out_free;
    logic     step;
    logic     in_take;
    t_kind    cls_kind;
    t_sev     cls_sev;
    t_colour  cls_colour;
    t_led_ctl led_ctl;
    t_colour  n_colour;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_alert    <= GAS_ALERT_RST;
            r_gas_warning  <= GAS_WARNING_RST;
            r_temp_high    <= TEMP_HIGH_RST;
            r_temp_low     <= TEMP_LOW_RST;
            r_blink_period <= BLINK_PERIOD_RST;
            r_flash_period <= FLASH_PERIOD_RST;
            r_blink_count  <= BLINK_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAS_ALERT:    r_gas_alert    <= i_cfg_wdata[GAS_W-1:0];
                REG_GAS_WARNING:  r_gas_warning  <= i_cfg_wdata[GAS_W-1:0];
                REG_TEMP_HIGH:    r_temp_high    <= t_temp'(i_cfg_wdata[TEMP_W-1:0]);
                REG_TEMP_LOW:     r_temp_low     <= t_temp'(i_cfg_wdata[TEMP_W-1:0]);
                REG_BLINK_PERIOD: r_blink_period <= i_cfg_wdata;
                REG_FLASH_PERIOD: r_flash_period <= i_cfg_wdata;
                REG_BLINK_COUNT:  r_blink_count  <= i_cfg_wdata[TOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_gas    <= i_gas_level;
            r_in_temp   <= i_object_temp;
            r_in_tvalid <= i_temp_valid;
            r_in_link   <= i_link_up;
            r_in_now    <= TIME_BITS'(i_now_ms);
        end
    end

    aslc_classify u_classify (
        .i_gas_level   (r_in_gas),
        .i_object_temp (r_in_temp),
        .i_temp_valid  (r_in_tvalid),
        .i_gas_alert   (r_gas_alert),
        .i_gas_warning (r_gas_warning),
        .i_temp_high   (r_temp_high),
        .i_temp_low    (r_temp_low),
        .o_kind        (cls_kind),
        .o_sev         (cls_sev),
        .o_colour      (cls_colour)
    );

    aslc_link_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_link_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_link_up      (r_in_link),
        .i_now          (r_in_now),
        .i_blink_period (r_blink_period),
        .i_flash_period (r_flash_period),
        .i_blink_count  (r_blink_count),
        .o_ctl          (led_ctl)
    );

    always_comb begin
        n_colour = '{red: CH_OFF, green: CH_OFF, blue: CH_OFF};
        if (led_ctl.refresh) begin
            if (led_ctl.show_alarm) begin
                n_colour = cls_colour;
            end else if (led_ctl.blue_full) begin
                n_colour.blue = CH_FULL;
            end else if (led_ctl.blue_dim) begin
                n_colour.blue = CH_DIM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_kind    <= cls_kind;
            r_out_sev     <= cls_sev;
            r_out_refresh <= led_ctl.refresh;
            r_out_colour  <= n_colour;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_alarm_kind     = r_out_kind;
    assign o_alarm_severity = r_out_sev;
    assign o_led_refresh    = r_out_refresh;
    assign o_led_red        = r_out_colour.red;
    assign o_led_green      = r_out_colour.green;
    assign o_led_blue       = r_out_colour.blue;

endmodule

`default_nettype wire

### hw/rtl/aslc_classify.sv
// ----------------------------------------------------------------------------
// Alarm classifier
// Ranks gas and temperature rules by priority and picks the alarm color,
// or the red-to-green gas gradient when there is no gas or heat alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module aslc_classify
    import aslc_pkg::*;
(
    input  wire t_gas    i_gas_level,
    input  wire t_temp   i_object_temp,
    input  wire logic    i_temp_valid,
    input  wire t_gas    i_gas_alert,
    input  wire t_gas    i_gas_warning,
    input  wire t_temp   i_temp_high,
    input  wire t_temp   i_temp_low,
    output t_kind        o_kind,
    output t_sev         o_sev,
    output t_colour      o_colour
);

    logic [GAS_W+4:0]       gas_x17;
    logic [GRAD_Z_W-1:0]    grad_z;
    logic [GRAD_PROD_W-1:0] grad_prod;
    logic [8:0]             grad_q;

    always_comb begin
        if (i_gas_level >= i_gas_alert) begin
            o_kind = KIND_GAS;
            o_sev  = SEV_HIGH;
        end else if (i_gas_level >= i_gas_warning) begin
            o_kind = KIND_WARNING;
            o_sev  = SEV_MEDIUM;
        end else if (i_temp_valid && (i_object_temp >= i_temp_high)) begin
            o_kind = KIND_HOT;
            o_sev  = SEV_HIGH;
        end else if (i_temp_valid && (i_object_temp <= i_temp_low)) begin
            o_kind = KIND_COLD;
            o_sev  = SEV_MEDIUM;
        end else begin
            o_kind = KIND_NONE;
            o_sev  = SEV_LOW;
        end
    end

    assign gas_x17   = {1'b0, i_gas_level, 4'b0000} + {5'b00000, i_gas_level};
    assign grad_z    = gas_x17[GAS_W+4:3];
    assign grad_prod = GRAD_PROD_W'(grad_z) * GRAD_PROD_W'(GRAD_RECIP);
    assign grad_q    = grad_prod[GRAD_SHIFT+8:GRAD_SHIFT];

    always_comb begin
        case (o_kind)
            KIND_GAS:     o_colour = '{red: CH_FULL, green: CH_OFF, blue: CH_OFF};
            KIND_WARNING: o_colour = '{red: CH_FULL, green: CH_AMBER, blue: CH_OFF};
            KIND_HOT:     o_colour = '{red: CH_OFF, green: CH_OFF, blue: CH_FULL};
            default: begin
                if (grad_q > 9'd255) begin
                    o_colour = '{red: CH_FULL, green: CH_OFF, blue: CH_OFF};
                end else begin
                    o_colour = '{red: grad_q[7:0], green: CH_FULL - grad_q[7:0],
                                 blue: CH_OFF};
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/aslc_link_seq.sv
// ----------------------------------------------------------------------------
// Link status sequencer
// Tracks the link, runs the loss blink after a drop and the offline flash
// while the link stays down, and decides what the LED shows for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module aslc_link_seq
    import aslc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic                 i_link_up,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire t_period              i_blink_period,
    input  wire t_period              i_flash_period,
    input  wire t_toggles             i_blink_count,
    output t_led_ctl                  o_ctl
);

    logic                 r_prev_link;
    t_toggles             r_blinks_left;
    logic                 r_blink_phase;
    logic [TIME_BITS-1:0] r_last_blink;
    logic                 r_flash_phase;
    logic [TIME_BITS-1:0] r_last_flash;

    logic                 n_prev_link;
    t_toggles             n_blinks_left;
    logic                 n_blink_phase;
    logic [TIME_BITS-1:0] n_last_blink;
    logic                 n_flash_phase;
    logic [TIME_BITS-1:0] n_last_flash;

    t_toggles             blinks_eff;
    logic [TIME_BITS-1:0] blink_age;
    logic [TIME_BITS-1:0] flash_age;

    assign blinks_eff = ((i_link_up != r_prev_link) && !i_link_up) ? i_blink_count
                                                                    : r_blinks_left;
    assign blink_age  = i_now - r_last_blink;
    assign flash_age  = i_now - r_last_flash;

    always_comb begin
        n_prev_link   = i_link_up;
        n_blinks_left = blinks_eff;
        n_blink_phase = r_blink_phase;
        n_last_blink  = r_last_blink;
        n_flash_phase = r_flash_phase;
        n_last_flash  = r_last_flash;
        o_ctl         = '0;
        if (i_link_up && (blinks_eff == '0)) begin
            o_ctl.refresh    = 1'b1;
            o_ctl.show_alarm = 1'b1;
        end else if (blinks_eff != '0) begin
            if (blink_age >= TIME_BITS'(i_blink_period)) begin
                n_last_blink    = i_now;
                n_blink_phase   = !r_blink_phase;
                n_blinks_left   = blinks_eff - t_toggles'(1);
                o_ctl.refresh   = 1'b1;
                o_ctl.blue_full = !r_blink_phase;
            end
        end else if (!i_link_up) begin
            if (flash_age >= TIME_BITS'(i_flash_period)) begin
                n_last_flash   = i_now;
                n_flash_phase  = !r_flash_phase;
                o_ctl.refresh  = 1'b1;
                o_ctl.blue_dim = !r_flash_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_link   <= 1'b0;
            r_blinks_left <= '0;
            r_blink_phase <= 1'b0;
            r_last_blink  <= '0;
            r_flash_phase <= 1'b0;
            r_last_flash  <= '0;
        end else if (i_step) begin
            r_prev_link   <= n_prev_link;
            r_blinks_left <= n_blinks_left;
            r_blink_phase <= n_blink_phase;
            r_last_blink  <= n_last_blink;
            r_flash_phase <= n_flash_phase;
            r_last_flash  <= n_last_flash;
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Alarm status LED controller testbench
// Sends sensor samples through the valid/stall input channel in random bursts
// and checks every result item against a predictor of the alarm rules and of
// the link-loss blink and offline flash. The run moves through several
// register settings, the extremes among them, with a random stall pattern and
// long hold-offs on the output side.
// ----------------------------------------------------------------------------
module testbench;
    import aslc_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int GRADIENT_SPAN = 3000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 132;
    localparam int GAS_MAX       = 4095;
    localparam int TEMP_MIN      = -1120;
    localparam int TEMP_MAX      = 6080;
    localparam int PERIOD_MAX    = 65535;
    localparam int TOGGLES_MAX   = 15;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    typedef struct packed {
        t_gas        gas;
        t_temp       temp;
        logic        temp_ok;
        logic        link;
        logic [31:0] now;
    } t_sample;

    typedef struct packed {
        t_kind kind;
        t_sev  sev;
        logic  refresh;
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_status;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    t_gas              i_gas_level    = '0;
    t_temp             i_object_temp  = '0;
    logic              i_temp_valid   = 1'b0;
    logic              i_link_up      = 1'b0;
    logic [31:0]       i_now_ms       = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    t_kind             o_alarm_kind;
    t_sev              o_alarm_severity;
    logic              o_led_refresh;
    t_chan             o_led_red;
    t_chan             o_led_green;
    t_chan             o_led_blue;
    logic              i_cfg_we       = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx      = '0;
    logic [CFG_W-1:0]  i_cfg_wdata    = '0;

    // Register copies and sequencer state of the predictor.
    t_gas        cfg_alert        = GAS_ALERT_RST;
    t_gas        cfg_warning      = GAS_WARNING_RST;
    t_temp       cfg_temp_high    = TEMP_HIGH_RST;
    t_temp       cfg_temp_low     = TEMP_LOW_RST;
    t_period     cfg_blink_period = BLINK_PERIOD_RST;
    t_period     cfg_flash_period = FLASH_PERIOD_RST;
    t_toggles    cfg_blink_count  = BLINK_COUNT_RST;
    logic        link_seen        = 1'b0;
    t_toggles    blinks_pending   = '0;
    logic        blink_lit        = 1'b0;
    logic [31:0] last_blink_ms    = '0;
    logic        flash_lit        = 1'b0;
    logic [31:0] last_flash_ms    = '0;

    t_sample     pending_samples[$];
    t_status     expected_status[$];
    t_sample     next_sample;
    t_sample     seen_sample;
    t_status     want_status;
    t_status     got_status;
    bit          sample_taken   = 1'b0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          accepted_items = 0;
    int          checked_items  = 0;
    int          failures       = 0;
    int          cycle_count    = 0;
    int          hold_left      = 0;
    int          next_hold_at   = 300;
    int          mode_left      = 0;
    t_stall_mode stall_mode     = STALL_NONE;

    alarm_status_led_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_gas_level      (i_gas_level),
        .i_object_temp    (i_object_temp),
        .i_temp_valid     (i_temp_valid),
        .i_link_up        (i_link_up),
        .i_now_ms         (i_now_ms),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_alarm_kind     (o_alarm_kind),
        .o_alarm_severity (o_alarm_severity),
        .o_led_refresh    (o_led_refresh),
        .o_led_red        (o_led_red),
        .o_led_green      (o_led_green),
        .o_led_blue       (o_led_blue),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_status led_status_for(t_sample s);
        t_status     res;
        t_temp       reading;
        logic [31:0] elapsed;
        int unsigned ramp;
        reading     = s.temp;
        res.kind    = KIND_NONE;
        res.sev     = SEV_LOW;
        res.refresh = 1'b0;
        res.red     = CH_OFF;
        res.green   = CH_OFF;
        res.blue    = CH_OFF;
        if (s.gas >= cfg_alert) begin
            res.kind = KIND_GAS;
            res.sev  = SEV_HIGH;
        end else if (s.gas >= cfg_warning) begin
            res.kind = KIND_WARNING;
            res.sev  = SEV_MEDIUM;
        end else if (s.temp_ok && reading >= cfg_temp_high) begin
            res.kind = KIND_HOT;
            res.sev  = SEV_HIGH;
        end else if (s.temp_ok && reading <= cfg_temp_low) begin
            res.kind = KIND_COLD;
            res.sev  = SEV_MEDIUM;
        end

        if (s.link != link_seen) begin
            if (!s.link) begin
                blinks_pending = cfg_blink_count;
            end
            link_seen = s.link;
        end

        if (s.link && blinks_pending == 0) begin
            res.refresh = 1'b1;
            case (res.kind)
                KIND_GAS: begin
                    res.red = CH_FULL;
                end
                KIND_WARNING: begin
                    res.red   = CH_FULL;
                    res.green = CH_AMBER;
                end
                KIND_HOT: begin
                    res.blue = CH_FULL;
                end
                default: begin
                    ramp = s.gas * 32'd255 / GRADIENT_SPAN;
                    res.red   = (ramp > 255) ? CH_FULL : t_chan'(ramp);
                    res.green = (ramp > 255) ? CH_OFF : CH_FULL - t_chan'(ramp);
                end
            endcase
        end else if (blinks_pending != 0) begin
            elapsed = s.now - last_blink_ms;
            if (elapsed >= 32'(cfg_blink_period)) begin
                last_blink_ms  = s.now;
                blink_lit      = !blink_lit;
                blinks_pending = blinks_pending - 1'b1;
                res.refresh    = 1'b1;
                if (blink_lit) begin
                    res.blue = CH_FULL;
                end
            end
        end else if (!s.link) begin
            elapsed = s.now - last_flash_ms;
            if (elapsed >= 32'(cfg_flash_period)) begin
                last_flash_ms = s.now;
                flash_lit     = !flash_lit;
                res.refresh   = 1'b1;
                if (flash_lit) begin
                    res.blue = CH_DIM;
                end
            end
        end
        return res;
    endfunction

    function automatic int near(int centre, int lo, int hi);
        int v;
        v = centre + int'($urandom_range(0, 4)) - 2;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    task automatic add_sample(t_gas gas, t_temp temp, logic ok, logic link, logic [31:0] now);
        t_sample s;
        s.gas     = gas;
        s.temp    = temp;
        s.temp_ok = ok;
        s.link    = link;
        s.now     = now;
        pending_samples.push_back(s);
    endtask

    task automatic wait_until_idle();
        while (pending_samples.size() != 0 || i_valid || expected_status.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CIDX_W-1:0] reg_index, logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= reg_index;
        i_cfg_wdata <= value;
        case (reg_index)
            REG_GAS_ALERT:    cfg_alert        = value[GAS_W-1:0];
            REG_GAS_WARNING:  cfg_warning      = value[GAS_W-1:0];
            REG_TEMP_HIGH:    cfg_temp_high    = t_temp'(value[TEMP_W-1:0]);
            REG_TEMP_LOW:     cfg_temp_low     = t_temp'(value[TEMP_W-1:0]);
            REG_BLINK_PERIOD: cfg_blink_period = value[PER_W-1:0];
            REG_FLASH_PERIOD: cfg_flash_period = value[PER_W-1:0];
            REG_BLINK_COUNT:  cfg_blink_count  = value[TOG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(int alert, int warning, int hot, int cold,
                                  int blink_ms, int flash_ms, int toggles);
        wait_until_idle();
        write_register(REG_GAS_ALERT, CFG_W'(alert));
        write_register(REG_GAS_WARNING, CFG_W'(warning));
        write_register(REG_TEMP_HIGH, CFG_W'(hot));
        write_register(REG_TEMP_LOW, CFG_W'(cold));
        write_register(REG_BLINK_PERIOD, CFG_W'(blink_ms));
        write_register(REG_FLASH_PERIOD, CFG_W'(flash_ms));
        write_register(REG_BLINK_COUNT, CFG_W'(toggles));
        i_cfg_we <= 1'b0;
    endtask

    // Driver: holds each item until it is taken, then moves on in bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || sample_taken) begin
            sample_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                next_sample = pending_samples.pop_front();
                i_gas_level   <= next_sample.gas;
                i_object_temp <= next_sample.temp;
                i_temp_valid  <= next_sample.temp_ok;
                i_link_up     <= next_sample.link;
                i_now_ms      <= next_sample.now;
                i_valid       <= 1'b1;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall pattern plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (accepted_items >= next_hold_at) begin
            next_hold_at = next_hold_at + 350;
            hold_left    = $urandom_range(40, 80);
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= !i_stall;
            endcase
        end
    end

    // Monitor: predicts each accepted item and checks each accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            seen_sample = {i_gas_level, i_object_temp, i_temp_valid, i_link_up, i_now_ms};
            expected_status.push_back(led_status_for(seen_sample));
            sample_taken = 1'b1;
            accepted_items++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got_status = {o_alarm_kind, o_alarm_severity, o_led_refresh,
                          o_led_red, o_led_green, o_led_blue};
            if (expected_status.size() == 0) begin
                if (failures < MAX_REPORTS) begin
                    $display("Unexpected result item: kind %0d sev %0d refresh %0b %s",
                             got_status.kind, got_status.sev, got_status.refresh,
                             $sformatf("rgb %0d/%0d/%0d", got_status.red,
                                       got_status.green, got_status.blue));
                end
                failures++;
            end else begin
                want_status = expected_status.pop_front();
                if (got_status.kind !== want_status.kind || got_status.sev !== want_status.sev ||
                    got_status.refresh !== want_status.refresh ||
                    got_status.red !== want_status.red ||
                    got_status.green !== want_status.green ||
                    got_status.blue !== want_status.blue) begin
                    if (failures < MAX_REPORTS) begin
                        $write("Mismatch on item %0d: expected kind %0d sev %0d ",
                               checked_items, want_status.kind, want_status.sev);
                        $write("refresh %0b rgb %0d/%0d/%0d, ", want_status.refresh,
                               want_status.red, want_status.green, want_status.blue);
                        $display("got kind %0d sev %0d refresh %0b rgb %0d/%0d/%0d",
                                 got_status.kind, got_status.sev, got_status.refresh,
                                 got_status.red, got_status.green, got_status.blue);
                    end
                    failures++;
                end
                checked_items++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] clock_ms;
        logic        link_now;
        logic        link_bit;
        int          link_run;
        int          span;
        int          gas_v;
        int          temp_v;
        int          alert_v;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Alarm priorities and colors under the reset settings.
        add_sample(12'd0, 14'sd0, 1'b0, 1'b1, 32'd10);
        add_sample(12'd4095, 14'sd6080, 1'b1, 1'b1, 32'd20);
        add_sample(12'd1000, 14'sd0, 1'b1, 1'b1, 32'd30);
        add_sample(12'd999, 14'sd0, 1'b1, 1'b1, 32'd40);
        add_sample(12'd500, 14'sd0, 1'b1, 1'b1, 32'd50);
        add_sample(12'd499, 14'sd960, 1'b1, 1'b1, 32'd60);
        add_sample(12'd499, 14'sd959, 1'b1, 1'b1, 32'd70);
        add_sample(12'd0, 14'sd960, 1'b0, 1'b1, 32'd80);
        add_sample(12'd300, -14'sd320, 1'b1, 1'b1, 32'd90);
        add_sample(12'd0, -14'sd1120, 1'b1, 1'b1, 32'd100);
        add_sample(12'd0, -14'sd1120, 1'b0, 1'b1, 32'd110);
        // Link drop starts the blink; the link comes back while it runs.
        add_sample(12'd0, 14'sd0, 1'b1, 1'b0, 32'd1000);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b0, 32'd1100);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b1, 32'd1400);
        add_sample(12'd4095, 14'sd0, 1'b1, 1'b1, 32'd1700);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b1, 32'd2000);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b1, 32'd2300);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b1, 32'd2600);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b1, 32'd2650);

        // No toggles and zero periods: the drop goes straight to the flash.
        apply_settings(GAS_MAX, GAS_MAX, TEMP_MAX, TEMP_MIN, 0, 0, 0);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b0, 32'd5000);
        add_sample(12'd0, 14'sd0, 1'b1, 1'b0, 32'd5000);
        add_sample(12'd4095, 14'sd0, 1'b1, 1'b0, 32'd5001);
        add_sample(12'd3000, 14'sd0, 1'b1, 1'b1, 32'd5002);
        add_sample(12'd4094, 14'sd6080, 1'b1, 1'b1, 32'd5003);
        add_sample(12'd4094, -14'sd1120, 1'b1, 1'b1, 32'd5004);

        clock_ms = 32'd6000;
        link_now = 1'b1;
        link_run = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(GAS_ALERT_RST, GAS_WARNING_RST, TEMP_HIGH_RST, TEMP_LOW_RST,
                                  BLINK_PERIOD_RST, FLASH_PERIOD_RST, BLINK_COUNT_RST);
                1: apply_settings(0, 0, TEMP_MIN, TEMP_MIN, 1, 1, TOGGLES_MAX);
                2: apply_settings(GAS_MAX, GAS_MAX, TEMP_MAX, TEMP_MAX, PERIOD_MAX, PERIOD_MAX, 0);
                default: begin
                    alert_v = $urandom_range(0, GAS_MAX);
                    apply_settings(alert_v, $urandom_range(0, alert_v),
                                   int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                                   int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN,
                                   $urandom_range(1, 400), $urandom_range(1, 600),
                                   $urandom_range(0, TOGGLES_MAX));
                end
            endcase

            span = (cfg_blink_period > cfg_flash_period) ? cfg_blink_period : cfg_flash_period;
            span = span + span / 2 + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (link_run == 0) begin
                    link_now = !link_now;
                    link_run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                                           : $urandom_range(4, 40);
                end
                link_run--;
                link_bit = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : link_now;

                case ($urandom_range(0, 19))
                    0, 1:    clock_ms = $urandom();
                    2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
                    3:       clock_ms = clock_ms - $urandom_range(0, span);
                    default: clock_ms = clock_ms + $urandom_range(0, span);
                endcase

                case ($urandom_range(0, 5))
                    0:       gas_v = near(cfg_alert, 0, GAS_MAX);
                    1:       gas_v = near(cfg_warning, 0, GAS_MAX);
                    2, 3:    gas_v = $urandom_range(0, cfg_warning);
                    4:       gas_v = ($urandom_range(0, 1) != 0) ? GAS_MAX : 0;
                    default: gas_v = $urandom_range(0, GAS_MAX);
                endcase

                case ($urandom_range(0, 4))
                    0:       temp_v = near(cfg_temp_high, TEMP_MIN, TEMP_MAX);
                    1:       temp_v = near(cfg_temp_low, TEMP_MIN, TEMP_MAX);
                    2:       temp_v = ($urandom_range(0, 1) != 0) ? TEMP_MAX : TEMP_MIN;
                    default: temp_v = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
                endcase

                add_sample(t_gas'(gas_v), t_temp'(temp_v), ($urandom_range(0, 4) != 0),
                           link_bit, clock_ms);
            end
        end

        wait_until_idle();
        if (failures == 0 && expected_status.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
